### rtl/dpg_pkg.sv
// ----------------------------------------------------------------------------
// dpg_pkg
// Shared types, widths and the microcode table of the distinct permutation
// generator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dpg_pkg;

  localparam int MAX_LEN   = 8;
  localparam int ELEM_BITS = 8;
  localparam int ADDR_W    = $clog2(MAX_LEN);
  localparam int CNT_W     = ADDR_W + 1;     // holds 0..MAX_LEN
  localparam int LVL_W     = CNT_W + 1;      // signed level, -1..MAX_LEN-2
  localparam int LEN_W     = 4;
  localparam int PERM_W    = 16;
  localparam int PC_W      = 5;

  localparam logic [PERM_W-1:0] PERM_MAX = '1;

  typedef enum logic [2:0] {
    RD_NONE, RD_LVL, RD_I, RD_J, RD_K, RD_KP1
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE, WR_LVL_RD, WR_I_A
  } wr_sel_t;

  typedef enum logic [1:0] {LV_HOLD, LV_INIT, LV_DEC} lvl_op_t;
  typedef enum logic [1:0] {I_HOLD, I_LOAD, I_INC} i_op_t;
  typedef enum logic [1:0] {J_HOLD, J_LVL, J_INC} j_op_t;
  typedef enum logic [1:0] {K_HOLD, K_ZERO, K_LVL1, K_INC} k_op_t;
  typedef enum logic [1:0] {ST_NONE, ST_LVL_I, ST_K_K} stk_op_t;
  typedef enum logic [1:0] {OUT_NONE, OUT_ELEM, OUT_EXH} out_op_t;
  typedef enum logic [1:0] {FL_NONE, FL_START, FL_EMIT, FL_DONE} flag_op_t;

  typedef enum logic [3:0] {
    CD_NEVER, CD_ALWAYS, CD_DONE, CD_NSTART, CD_LVL_NEG,
    CD_I_GE_N, CD_RD_EQ_C, CD_J_NE_I, CD_K_GE_NM1, CD_K_NE_NM1
  } cond_t;

  typedef struct packed {
    logic done;
    logic nstart;
    logic lvl_neg;
    logic i_ge_n;
    logic rd_eq_c;
    logic j_ne_i;
    logic k_ge_nm1;
    logic k_ne_nm1;
  } flags_t;

  typedef struct packed {
    rd_sel_t             rd_sel;
    wr_sel_t             wr_sel;
    lvl_op_t             lvl_op;
    i_op_t               i_op;
    j_op_t               j_op;
    k_op_t               k_op;
    stk_op_t             stk_op;
    out_op_t             out_op;
    flag_op_t            flag_op;
    logic                a_ld;
    logic                c_ld;
    cond_t               cond;
    logic [PC_W-1:0]     target;
    logic                fin;
  } uword_t;

  localparam uword_t UW_NOP = '{
    rd_sel: RD_NONE, wr_sel: WR_NONE, lvl_op: LV_HOLD, i_op: I_HOLD,
    j_op: J_HOLD, k_op: K_HOLD, stk_op: ST_NONE, out_op: OUT_NONE,
    flag_op: FL_NONE, a_ld: 1'b0, c_ld: 1'b0, cond: CD_NEVER,
    target: '0, fin: 1'b0
  };

  // Program addresses
  localparam logic [PC_W-1:0] S_DISP   = PC_W'(0);
  localparam logic [PC_W-1:0] S_CHKST  = PC_W'(1);
  localparam logic [PC_W-1:0] S_NEXT   = PC_W'(2);
  localparam logic [PC_W-1:0] S_LOOP   = PC_W'(3);
  localparam logic [PC_W-1:0] S_ULD    = PC_W'(4);
  localparam logic [PC_W-1:0] S_URD    = PC_W'(5);
  localparam logic [PC_W-1:0] S_UWA    = PC_W'(6);
  localparam logic [PC_W-1:0] S_UWB    = PC_W'(7);
  localparam logic [PC_W-1:0] S_SRCH   = PC_W'(8);
  localparam logic [PC_W-1:0] S_SCHK   = PC_W'(9);
  localparam logic [PC_W-1:0] S_SREF   = PC_W'(10);
  localparam logic [PC_W-1:0] S_CMP    = PC_W'(11);
  localparam logic [PC_W-1:0] S_CRD    = PC_W'(12);
  localparam logic [PC_W-1:0] S_FOUND  = PC_W'(13);
  localparam logic [PC_W-1:0] S_SRD    = PC_W'(14);
  localparam logic [PC_W-1:0] S_SWA    = PC_W'(15);
  localparam logic [PC_W-1:0] S_SWB    = PC_W'(16);
  localparam logic [PC_W-1:0] S_DESC   = PC_W'(17);
  localparam logic [PC_W-1:0] S_DSET   = PC_W'(18);
  localparam logic [PC_W-1:0] S_EMITP  = PC_W'(19);
  localparam logic [PC_W-1:0] S_EREAD  = PC_W'(20);
  localparam logic [PC_W-1:0] S_EMIT   = PC_W'(21);
  localparam logic [PC_W-1:0] S_FAIL   = PC_W'(22);
  localparam logic [PC_W-1:0] S_FIN    = PC_W'(23);
  localparam logic [PC_W-1:0] S_EXH    = PC_W'(24);
  localparam logic [PC_W-1:0] S_FIRST  = PC_W'(25);

  function automatic uword_t dpg_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = UW_NOP;
    unique case (pc)
      S_DISP:  begin w.cond = CD_DONE; w.target = S_EXH; end
      S_CHKST: begin w.cond = CD_NSTART; w.target = S_FIRST; end
      S_NEXT:  begin w.lvl_op = LV_INIT; end
      S_LOOP:  begin w.cond = CD_LVL_NEG; w.target = S_FIN; end
      // undo the pending swap of slot lvl with slot i
      S_ULD:   begin w.i_op = I_LOAD; w.rd_sel = RD_LVL; end
      S_URD:   begin w.rd_sel = RD_I; w.a_ld = 1'b1; end
      S_UWA:   begin w.wr_sel = WR_LVL_RD; end
      S_UWB:   begin w.wr_sel = WR_I_A; end
      // look for the next candidate with no equal element before it
      S_SRCH:  begin w.i_op = I_INC; end
      S_SCHK:  begin
        w.cond = CD_I_GE_N; w.target = S_FAIL;
        w.rd_sel = RD_I; w.j_op = J_LVL;
      end
      S_SREF:  begin w.c_ld = 1'b1; w.rd_sel = RD_J; end
      S_CMP:   begin w.j_op = J_INC; w.cond = CD_RD_EQ_C; w.target = S_SRCH; end
      S_CRD:   begin w.rd_sel = RD_J; w.cond = CD_J_NE_I; w.target = S_CMP; end
      // take it: record, swap, reset deeper levels
      S_FOUND: begin w.stk_op = ST_LVL_I; w.rd_sel = RD_LVL; end
      S_SRD:   begin w.rd_sel = RD_I; w.a_ld = 1'b1; end
      S_SWA:   begin w.wr_sel = WR_LVL_RD; end
      S_SWB:   begin w.wr_sel = WR_I_A; w.k_op = K_LVL1; end
      S_DESC:  begin w.cond = CD_K_GE_NM1; w.target = S_EMITP; end
      S_DSET:  begin
        w.stk_op = ST_K_K; w.k_op = K_INC;
        w.cond = CD_ALWAYS; w.target = S_DESC;
      end
      // stream the arrangement out, one element per cycle
      S_EMITP: begin w.flag_op = FL_EMIT; w.k_op = K_ZERO; end
      S_EREAD: begin w.rd_sel = RD_K; end
      S_EMIT:  begin
        w.out_op = OUT_ELEM; w.rd_sel = RD_KP1; w.k_op = K_INC;
        w.cond = CD_K_NE_NM1; w.target = S_EMIT; w.fin = 1'b1;
      end
      S_FAIL:  begin w.lvl_op = LV_DEC; w.cond = CD_ALWAYS; w.target = S_LOOP; end
      S_FIN:   begin w.flag_op = FL_DONE; end
      S_EXH:   begin w.out_op = OUT_EXH; w.fin = 1'b1; end
      S_FIRST: begin
        w.flag_op = FL_START; w.k_op = K_ZERO;
        w.cond = CD_ALWAYS; w.target = S_DESC;
      end
      default: begin w.fin = 1'b1; end
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

### rtl/distinct_permutation_generator_unit.sv
// ----------------------------------------------------------------------------
// distinct_permutation_generator_unit
// Enumerates the distinct permutations of a loaded sequence in recursive
// swap order, one permutation per request until exhausted, streamed one element per cycle.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake             | Payload
//  ---------+-----------------------+-----------------------------------------
//  input    | start, busy           | in_operation, in_value
//  result   | out_strobe            | out_element, out_position, out_last,
//           |                       | out_perm_number, out_exhausted
//  config   | cfg_we                | cfg_data (sequence length)
//
//  busy never rises for a load.
//  A request runs a microprogram on a single-read, single-write element
//  store: swaps and duplicate compares go through its single ports, and
//  the permutation streams out at one element per cycle after setup. A
//  request after the first takes longer for each level it unwinds; an
//  exhausted request answers with a single exhausted item.
//  Reset is synchronous, active low; the store itself is not cleared.
//  Results leave through a registered stage and cannot be stalled.
//
`timescale 1ns / 1ps
`default_nettype none

module distinct_permutation_generator_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // item channel
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          in_operation,
  input  wire logic [dpg_pkg::ELEM_BITS-1:0] in_value,
  // result channel
  output logic                               out_strobe,
  output logic [dpg_pkg::ELEM_BITS-1:0]      out_element,
  output logic [dpg_pkg::ADDR_W-1:0]         out_position,
  output logic                               out_last,
  output logic [dpg_pkg::PERM_W-1:0]         out_perm_number,
  output logic                               out_exhausted,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [dpg_pkg::LEN_W-1:0]     cfg_data
);
  import dpg_pkg::*;

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic   accept, go, load;
  uword_t ctl;
  flags_t flags;

  assign accept = start && !busy;
  assign go     = accept && in_operation;
  assign load   = accept && !in_operation;

  // --------------------------------------------------------------------------
  // Control state
  // --------------------------------------------------------------------------
  logic [LEN_W-1:0]  len_r;
  logic [ADDR_W-1:0] lp_r, lp_nxt;
  logic [ADDR_W-1:0] cur_r;
  logic [PERM_W-1:0] count_r;
  logic              started_r, done_r;
  logic [ADDR_W-1:0] stack_r [MAX_LEN];

  // Effective length: zero acts as one, clamp at the store depth.
  logic [CNT_W-1:0] n_w, nm1_w;

  always_comb begin
    priority if (len_r == '0) begin
      n_w = CNT_W'(1);
    end else if (LEN_W'(len_r) > LEN_W'(MAX_LEN)) begin
      n_w = CNT_W'(MAX_LEN);
    end else begin
      n_w = CNT_W'(len_r);
    end
  end
  assign nm1_w = n_w - CNT_W'(1);

  // Load pointer wraps at the effective length.
  logic [CNT_W-1:0] lp_inc;
  assign lp_inc = {1'b0, lp_r} + CNT_W'(1);
  assign lp_nxt = (lp_inc >= n_w) ? '0 : lp_inc[ADDR_W-1:0];

  // --------------------------------------------------------------------------
  // Scratch registers of the datapath
  // --------------------------------------------------------------------------
  logic signed [LVL_W-1:0] lvl_r;
  logic [CNT_W-1:0]        i_r, j_r, k_r;
  logic [ELEM_BITS-1:0]    rd_r, a_r, c_r;

  logic [CNT_W-1:0]        lvl_u;
  assign lvl_u = lvl_r[CNT_W-1:0];

  // Starting level of a request: one above the deepest, clamped to n-2.
  logic signed [LVL_W-1:0] lvl_t, lvl_m, lvl_init;
  always_comb begin
    lvl_t    = $signed(LVL_W'(cur_r)) - $signed(LVL_W'(1));
    lvl_m    = $signed(LVL_W'(n_w)) - $signed(LVL_W'(2));
    lvl_init = (lvl_t < lvl_m) ? lvl_t : lvl_m;
  end

  // Saved index of this level, forced back to lvl if stale.
  logic [ADDR_W-1:0] stk_rd;
  logic [CNT_W-1:0]  i_saved;
  always_comb begin
    stk_rd  = stack_r[lvl_r[ADDR_W-1:0]];
    i_saved = CNT_W'(stk_rd);
    if (i_saved < lvl_u || i_saved >= n_w) begin
      i_saved = lvl_u;
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.lvl_op)
      LV_INIT: lvl_r <= lvl_init;
      LV_DEC:  lvl_r <= lvl_r - LVL_W'(1);
      default: lvl_r <= lvl_r;
    endcase
    unique case (ctl.i_op)
      I_LOAD:  i_r <= i_saved;
      I_INC:   i_r <= i_r + CNT_W'(1);
      default: i_r <= i_r;
    endcase
    unique case (ctl.j_op)
      J_LVL:   j_r <= lvl_u;
      J_INC:   j_r <= j_r + CNT_W'(1);
      default: j_r <= j_r;
    endcase
    unique case (ctl.k_op)
      K_ZERO:  k_r <= '0;
      K_LVL1:  k_r <= lvl_u + CNT_W'(1);
      K_INC:   k_r <= k_r + CNT_W'(1);
      default: k_r <= k_r;
    endcase
    if (ctl.a_ld) a_r <= rd_r;
    if (ctl.c_ld) c_r <= rd_r;
  end

  // --------------------------------------------------------------------------
  // Element store: one read port with registered data, one write port.
  // Also the working array that the swaps rearrange.
  // --------------------------------------------------------------------------
  logic [ELEM_BITS-1:0] store_mem [MAX_LEN];
  logic                 rd_en, wr_en;
  logic [ADDR_W-1:0]    rd_addr, wr_addr;
  logic [ELEM_BITS-1:0] wr_data;

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    unique case (ctl.rd_sel)
      RD_LVL:  rd_addr = lvl_r[ADDR_W-1:0];
      RD_I:    rd_addr = i_r[ADDR_W-1:0];
      RD_J:    rd_addr = j_r[ADDR_W-1:0];
      RD_K:    rd_addr = k_r[ADDR_W-1:0];
      RD_KP1:  rd_addr = k_r[ADDR_W-1:0] + ADDR_W'(1);
      default: rd_en   = 1'b0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = lp_r;
    wr_data = in_value;
    if (load) begin
      wr_en = 1'b1;
    end else begin
      unique case (ctl.wr_sel)
        WR_LVL_RD: begin
          wr_en   = 1'b1;
          wr_addr = lvl_r[ADDR_W-1:0];
          wr_data = rd_r;
        end
        WR_I_A: begin
          wr_en   = 1'b1;
          wr_addr = i_r[ADDR_W-1:0];
          wr_data = a_r;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_r <= store_mem[rd_addr];
    if (wr_en) store_mem[wr_addr] <= wr_data;
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign flags = '{
    done:     done_r,
    nstart:   !started_r,
    lvl_neg:  lvl_r[LVL_W-1],
    i_ge_n:   (i_r >= n_w),
    rd_eq_c:  (rd_r == c_r),
    j_ne_i:   (j_r != i_r),
    k_ge_nm1: (k_r >= nm1_w),
    k_ne_nm1: (k_r != nm1_w)
  };

  dpg_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .flags (flags),
    .ctl   (ctl),
    .busy  (busy)
  );

  // --------------------------------------------------------------------------
  // Control state update. Loads and length writes restart the enumeration
  // from whatever arrangement the store holds now.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= LEN_W'(3);
      lp_r      <= '0;
      cur_r     <= '0;
      count_r   <= '0;
      started_r <= 1'b0;
      done_r    <= 1'b0;
      for (int s = 0; s < MAX_LEN; s++) begin
        stack_r[s] <= '0;
      end
    end else begin
      if (cfg_we) len_r <= cfg_data;
      if (load)   lp_r  <= lp_nxt;

      priority if (cfg_we || load) begin
        started_r <= 1'b0;
        done_r    <= 1'b0;
        count_r   <= '0;
        cur_r     <= '0;
      end else begin
        unique case (ctl.flag_op)
          FL_START: started_r <= 1'b1;
          FL_EMIT: begin
            cur_r <= nm1_w[ADDR_W-1:0];
            if (count_r != PERM_MAX) count_r <= count_r + PERM_W'(1);
          end
          FL_DONE: begin
            done_r <= 1'b1;
            cur_r  <= '0;
          end
          default: ;
        endcase
      end

      unique case (ctl.stk_op)
        ST_LVL_I: stack_r[lvl_r[ADDR_W-1:0]] <= i_r[ADDR_W-1:0];
        ST_K_K:   stack_r[k_r[ADDR_W-1:0]]   <= k_r[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Result stage
  // --------------------------------------------------------------------------
  logic strobe_r;
  assign out_strobe = strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= (ctl.out_op != OUT_NONE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.out_op)
      OUT_ELEM: begin
        out_element     <= rd_r;
        out_position    <= k_r[ADDR_W-1:0];
        out_last        <= (k_r == nm1_w);
        out_perm_number <= count_r;
        out_exhausted   <= 1'b0;
      end
      OUT_EXH: begin
        out_element     <= '0;
        out_position    <= '0;
        out_last        <= 1'b1;
        out_perm_number <= count_r;
        out_exhausted   <= 1'b1;
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go |=> busy)
    else $error("request accepted but sequencer not running");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> !busy)
    else $error("load started the sequencer");

  a_exh_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_exhausted |-> out_last && (out_position == '0))
    else $error("exhausted item malformed");

  a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_exhausted && out_last |-> (CNT_W'(out_position) == nm1_w))
    else $error("last element at wrong position");
`endif

endmodule

`default_nettype wire

### rtl/dpg_useq.sv
// ----------------------------------------------------------------------------
// dpg_useq
// Microcode sequencer: step counter, control store lookup and branch logic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dpg_useq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            go,
  input  wire dpg_pkg::flags_t flags,
  output dpg_pkg::uword_t      ctl,
  output logic                 busy
);
  import dpg_pkg::*;

  logic [PC_W-1:0] pc_r, pc_nxt;
  logic            run_r, run_nxt;
  uword_t          word;
  logic            taken;

  assign word = dpg_rom(pc_r);
  assign ctl  = run_r ? word : UW_NOP;
  assign busy = run_r;

  always_comb begin
    unique case (word.cond)
      CD_NEVER:    taken = 1'b0;
      CD_ALWAYS:   taken = 1'b1;
      CD_DONE:     taken = flags.done;
      CD_NSTART:   taken = flags.nstart;
      CD_LVL_NEG:  taken = flags.lvl_neg;
      CD_I_GE_N:   taken = flags.i_ge_n;
      CD_RD_EQ_C:  taken = flags.rd_eq_c;
      CD_J_NE_I:   taken = flags.j_ne_i;
      CD_K_GE_NM1: taken = flags.k_ge_nm1;
      CD_K_NE_NM1: taken = flags.k_ne_nm1;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt  = pc_r;
    run_nxt = run_r;
    priority if (go) begin
      pc_nxt  = S_DISP;
      run_nxt = 1'b1;
    end else if (run_r) begin
      priority if (taken) begin
        pc_nxt = word.target;
      end else if (word.fin) begin
        run_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + PC_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r  <= S_DISP;
      run_r <= 1'b0;
    end else begin
      pc_r  <= pc_nxt;
      run_r <= run_nxt;
    end
  end

endmodule

`default_nettype wire

### dv/distinct_permutation_generator_unit_tb.sv
// ----------------------------------------------------------------------------
// distinct_permutation_generator_unit_tb
// Self-checking testbench for the distinct permutation generator. Loads
// sequences, requests permutations and compares every streamed element with
// a cycle-free predictor of the swap-order enumeration. It also covers
// length writes, restarts and the exhausted answer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module distinct_permutation_generator_unit_tb;

  localparam int NSLOT = dpg_pkg::MAX_LEN;
  localparam int EW    = dpg_pkg::ELEM_BITS;
  localparam int PW    = dpg_pkg::ADDR_W;
  localparam int CW    = dpg_pkg::PERM_W;
  localparam int LW    = dpg_pkg::LEN_W;

  localparam logic OP_LOAD = 1'b0;   // write one element at the load pointer
  localparam logic OP_NEXT = 1'b1;   // ask for the next distinct permutation

  localparam int CLK_HALF      = 5;
  localparam int ITEM_TARGET   = 310;
  localparam int SETTLE_CYCLES = 8;     // margin after the queue drains
  localparam int STALL_LIMIT   = 4000;  // must exceed the worst unwind at length 8
  localparam int MAX_REPORTS   = 10;

  // One streamed element of a permutation (or the single exhausted answer).
  typedef struct packed {
    logic [EW-1:0] element;
    logic [PW-1:0] position;
    logic          last;
    logic [CW-1:0] perm_number;
    logic          exhausted;
  } perm_elem_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          start = 1'b0;
  logic          in_operation = 1'b0;
  logic [EW-1:0] in_value = '0;
  logic          cfg_we = 1'b0;
  logic [LW-1:0] cfg_data = '0;
  logic          busy;
  logic          out_strobe;
  logic [EW-1:0] out_element;
  logic [PW-1:0] out_position;
  logic          out_last;
  logic [CW-1:0] out_perm_number;
  logic          out_exhausted;

  distinct_permutation_generator_unit u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_operation    (in_operation),
    .in_value        (in_value),
    .out_strobe      (out_strobe),
    .out_element     (out_element),
    .out_position    (out_position),
    .out_last        (out_last),
    .out_perm_number (out_perm_number),
    .out_exhausted   (out_exhausted),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: a shadow of the element store (which the swaps permute
  // in place), the per-level loop indices and the enumeration flags.
  // --------------------------------------------------------------------------
  logic [EW-1:0] arr [NSLOT];
  logic [PW-1:0] choice [NSLOT];
  logic [PW-1:0] depth;
  logic [PW-1:0] load_ptr;
  logic [CW-1:0] emitted;
  bit            started;
  bit            finished;
  logic [LW-1:0] len_reg;

  perm_elem_t expected_elems[$];
  int         mismatch_count = 0;
  int         items_accepted = 0;
  int         stall_cycles = 0;
  bit         burst = 1'b0;   // when set, the sender sends back to back

  // Length 0 behaves as 1, anything past the store size as the store size.
  function automatic int active_len();
    if (len_reg == 0) return 1;
    if (len_reg > NSLOT) return NSLOT;
    return int'(len_reg);
  endfunction

  function automatic void restart_enum();
    started  = 1'b0;
    finished = 1'b0;
    emitted  = '0;
    depth    = '0;
  endfunction

  function automatic void reset_predictor();
    for (int k = 0; k < NSLOT; k++) begin
      arr[k]    = '0;
      choice[k] = '0;
    end
    load_ptr = '0;
    len_reg  = LW'(3);
    restart_enum();
  endfunction

  function automatic void swap_slots(int a, int b);
    logic [EW-1:0] t;
    t      = arr[a];
    arr[a] = arr[b];
    arr[b] = t;
  endfunction

  // True when no slot in [lo, hi) already holds the value at slot hi.
  function automatic bit unseen(int lo, int hi);
    for (int j = lo; j < hi; j++)
      if (arr[j] == arr[hi]) return 1'b0;
    return 1'b1;
  endfunction

  // Deeper levels start their scan at their own slot.
  function automatic void dive(int from, int n);
    for (int k = from; k < n - 1; k++) choice[k] = PW'(k);
    depth = PW'(n - 1);
  endfunction

  function automatic void push_perm(int n);
    perm_elem_t e;
    if (emitted != '1) emitted++;
    for (int k = 0; k < n; k++) begin
      e.element     = arr[k];
      e.position    = PW'(k);
      e.last        = (k == n - 1);
      e.perm_number = emitted;
      e.exhausted   = 1'b0;
      expected_elems.push_back(e);
    end
  endfunction

  function automatic void push_exhausted();
    perm_elem_t e;
    e.element     = '0;
    e.position    = '0;
    e.last        = 1'b1;
    e.perm_number = emitted;
    e.exhausted   = 1'b1;
    expected_elems.push_back(e);
  endfunction

  // Advances the shadow state by one accepted item and queues its results.
  function automatic void predict_item(logic op, logic [EW-1:0] v);
    int n;
    int lvl;
    int i;
    int p;
    n = active_len();
    if (op == OP_LOAD) begin
      p      = int'(load_ptr);
      arr[p] = v;
      p++;
      if (p >= n) p = 0;
      load_ptr = PW'(p);
      restart_enum();   // pending swaps stay in place
      return;
    end
    if (finished) begin
      push_exhausted();
      return;
    end
    if (!started) begin
      started = 1'b1;
      dive(0, n);
      push_perm(n);
      return;
    end
    // Unwind: undo the swap at this level, then look for the next slot whose
    // value has not already been tried here; give up a level if none is left.
    lvl = int'(depth) - 1;
    if (lvl > n - 2) lvl = n - 2;
    while (lvl >= 0) begin
      i = int'(choice[lvl]);
      if (i < lvl || i >= n) i = lvl;
      swap_slots(lvl, i);
      i++;
      while (i < n && !unseen(lvl, i)) i++;
      if (i < n) begin
        choice[lvl] = PW'(i);
        swap_slots(lvl, i);
        dive(lvl + 1, n);
        push_perm(n);
        return;
      end
      lvl--;
    end
    finished = 1'b1;
    depth    = '0;
    push_exhausted();
  endfunction

  // --------------------------------------------------------------------------
  // Result checking: every strobe is matched against the oldest expectation.
  // Outputs are sampled at the edge that ends the strobe cycle.
  // --------------------------------------------------------------------------
  function automatic void flag_mismatch(string what, perm_elem_t want, perm_elem_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("[%0t] %s: exp elem=%0d pos=%0d last=%0b perm=%0d exh=%0b",
               $realtime, what, want.element, want.position, want.last,
               want.perm_number, want.exhausted);
    if (mismatch_count <= MAX_REPORTS)
      $display("           got elem=%0d pos=%0d last=%0b perm=%0d exh=%0b",
               got.element, got.position, got.last, got.perm_number, got.exhausted);
  endfunction

  always @(posedge clk) begin
    perm_elem_t got;
    perm_elem_t want;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      got = '{out_element, out_position, out_last, out_perm_number, out_exhausted};
      if (expected_elems.size() == 0) begin
        flag_mismatch("result with nothing pending", '0, got);
      end else begin
        want = expected_elems.pop_front();
        if (got !== want) flag_mismatch("result mismatch", want, got);
      end
    end
  end

  // Watchdog: any accepted item, result or register write counts as progress.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start && busy === 1'b0) || out_strobe === 1'b1 || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("distinct_permutation_generator_unit regression: fail");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender. start is left high after acceptance; the next call either keeps
  // it high (no gap) or drops it, so it never sees two updates in one step.
  // --------------------------------------------------------------------------
  task automatic send_item(logic op, logic [EW-1:0] v);
    int gap;
    gap = burst ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    in_operation <= op;
    in_value     <= v;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_item(op, v);
    items_accepted++;
  endtask

  // Holds the sender off until every queued element has come out.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (expected_elems.size() != 0 || busy !== 1'b0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Only called while idle; a length write also restarts the enumeration.
  task automatic write_length(logic [LW-1:0] v);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we  <= 1'b0;
    len_reg = v;
    restart_enum();
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Length 3 straight out of reset, distinct values at both extremes; runs
  // all six permutations and into the exhausted answer. Pointer wraps at 3.
  task automatic test_reset_length();
    send_item(OP_LOAD, 8'h00);
    send_item(OP_LOAD, 8'hFF);
    send_item(OP_LOAD, 8'h5A);
    repeat (7) send_item(OP_NEXT, 8'h00);
  endtask

  // Requests after the end keep returning the exhausted answer.
  task automatic test_repeat_exhausted();
    send_item(OP_NEXT, 8'hFF);
  endtask

  // Length 0 acts as 1: one permutation, then exhausted.
  task automatic test_length_zero();
    wait_idle();
    write_length(LW'(0));
    send_item(OP_LOAD, 8'h81);
    repeat (2) send_item(OP_NEXT, 8'h00);
  endtask

  // 15 acts as 8. Fills every slot of the store (so nothing later reads an
  // unwritten entry) with repeated values to exercise the duplicate skip.
  task automatic test_length_above_max();
    logic [EW-1:0] vals [NSLOT];
    vals = '{8'h01, 8'h01, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h80, 8'h00};
    wait_idle();
    write_length(LW'(15));
    for (int k = 0; k < NSLOT; k++) send_item(OP_LOAD, vals[k]);
    repeat (2) send_item(OP_NEXT, 8'h00);
  endtask

  // A load mid-enumeration restarts from the current, still swapped, order.
  task automatic test_load_mid_enum();
    send_item(OP_LOAD, 8'hC3);
    send_item(OP_NEXT, 8'h00);
  endtask

  // A length write restarts as well; also hits the exact maximum length.
  task automatic test_length_write_restart();
    send_item(OP_NEXT, 8'h00);
    wait_idle();
    write_length(LW'(NSLOT));
    send_item(OP_NEXT, 8'h00);
  endtask

  // --------------------------------------------------------------------------
  // Random phases: mostly a full load followed by a run of requests (often
  // long enough to exhaust short sequences), now and then a length change,
  // and a few phases of stray loads and requests in any order.
  // --------------------------------------------------------------------------
  task automatic test_random_sequences();
    int n;
    int hi_v;
    int pick;
    while (items_accepted < ITEM_TARGET) begin
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, 19);
        wait_idle();
        if (pick == 0)      write_length(LW'(0));
        else if (pick == 1) write_length(LW'($urandom_range(NSLOT + 1, 15)));
        else if (pick < 5)  write_length(LW'($urandom_range(6, NSLOT)));
        else                write_length(LW'($urandom_range(1, 5)));
      end
      burst = ($urandom_range(0, 3) == 0);
      n = active_len();
      // small alphabets make duplicates common
      case ($urandom_range(0, 2))
        0:       hi_v = 255;
        1:       hi_v = 1;
        default: hi_v = 3;
      endcase
      if ($urandom_range(0, 7) != 0) begin
        for (int k = 0; k < n; k++) send_item(OP_LOAD, EW'($urandom_range(0, hi_v)));
        repeat ($urandom_range(1, 26)) send_item(OP_NEXT, EW'($urandom));
      end else begin
        repeat ($urandom_range(1, 6))
          send_item($urandom_range(0, 1) ? OP_NEXT : OP_LOAD, EW'($urandom));
      end
    end
    burst = 1'b0;
  endtask

  initial begin
    reset_predictor();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_length();
    test_repeat_exhausted();
    test_length_zero();
    test_length_above_max();
    test_load_mid_enum();
    test_length_write_restart();
    test_random_sequences();

    wait_idle();
    if (mismatch_count == 0 && expected_elems.size() == 0) begin
      $display("distinct_permutation_generator_unit regression: pass");
    end else begin
      $display("distinct_permutation_generator_unit regression: fail");
    end
    $finish;
  end

endmodule
